### rtl/core/pbrm_pkg.sv
// ----------------------------------------------------------------------------
// pbrm_pkg: shared types and constants for the peaking biquad / ring modulator
// Sample and coefficient formats, register indexes, saturation and the
// sine table generator used to build the oscillator ROM.
// ----------------------------------------------------------------------------
package pbrm_pkg;

    // Field formats
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 18;
    localparam int COEF_FRAC_BITS = 14;
    localparam int STEP_BITS      = 32;
    localparam int ACC_BITS       = COEF_BITS + SAMPLE_BITS + 3;
    localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
    localparam int RING_SHIFT     = 15;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Register map (index = byte address / 4)
    localparam int          CFG_ADDR_BITS = 5;
    localparam logic [2:0]  REG_ENABLES    = 3'd0;
    localparam logic [2:0]  REG_B0         = 3'd1;
    localparam logic [2:0]  REG_B1         = 3'd2;
    localparam logic [2:0]  REG_B2         = 3'd3;
    localparam logic [2:0]  REG_A1         = 3'd4;
    localparam logic [2:0]  REG_A2         = 3'd5;
    localparam logic [2:0]  REG_PHASE_STEP = 3'd6;

    // Enable bits
    localparam int EN_FILTER = 0;
    localparam int EN_RING   = 1;

    // Reset values
    localparam logic signed [COEF_BITS-1:0] COEF_ONE        = COEF_BITS'(16384);
    localparam logic [STEP_BITS-1:0]        PHASE_STEP_INIT = 32'd77922378;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } coef_set_t;

    typedef struct packed {
        logic ring_en;
        logic filt_en;
    } effect_flags_t;

    localparam logic signed [ACC_BITS-1:0] SAMPLE_MAX =
        ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] SAMPLE_MIN = -SAMPLE_MAX - ACC_BITS'(1);

    // Clamp a wide signed value to the sample range
    function automatic sample_t sat_sample(input logic signed [ACC_BITS-1:0] v);
        sample_t r;
        if (v > SAMPLE_MAX)
            r = SAMPLE_MAX[SAMPLE_BITS-1:0];
        else if (v < SAMPLE_MIN)
            r = SAMPLE_MIN[SAMPLE_BITS-1:0];
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

    // Sine table generator, evaluated at elaboration only
    localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

    // Entry i of a 2^tb sine table, 32767*sin(2*pi*i/2^tb), odd series in Q28
    function automatic sample_t sine_entry(input int unsigned i, input int unsigned tb);
        longint unsigned quarter;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned v;
        quarter = 64'd1 << (tb - 2);
        q       = longint'(i) >> (tb - 2);
        r       = longint'(i) & (quarter - 64'd1);
        if (q[0])
            r = quarter - r;
        x    = (r * TWO_PI_Q28) >> tb;
        x2   = (x * x) >> 28;
        term = x;
        sum  = longint'(x);
        for (int k = 0; k < 7; k++)
        begin
            term = ((term * x2) >> 28) / TAYLOR_DIV[k];
            if (k % 2 == 0)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = (longint'(sum) * 64'd32767 + (64'd1 << 27)) >> 28;
        if (v > 64'd32767)
            v = 64'd32767;
        if (q >= 64'd2)
            return -sample_t'(v[SAMPLE_BITS-1:0]);
        return sample_t'(v[SAMPLE_BITS-1:0]);
    endfunction

endpackage

### rtl/core/pbrm_front.sv
// ----------------------------------------------------------------------------
// pbrm_front: request intake and oscillator phase
// Accepts samples, advances the phase accumulator, tags each request with
// its sine table index and effect flags and pushes it into the queue.
// ----------------------------------------------------------------------------
module pbrm_front #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  pbrm_pkg::sample_t                   sample_in,
    input  logic [1:0]                          effect_enables,
    input  logic [pbrm_pkg::STEP_BITS-1:0]      phase_step,
    input  logic                                q_full,
    output logic                                q_push,
    output logic [pbrm_pkg::SAMPLE_BITS+SINE_TABLE_BITS+1:0] q_data
);
    import pbrm_pkg::*;

    logic [PHASE_BITS-1:0]      phase_reg;
    logic [PHASE_BITS-1:0]      phase_next;
    logic [SINE_TABLE_BITS-1:0] rom_idx;
    effect_flags_t              flags;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Phase advances per accepted sample, advanced value selects the sine
    assign phase_next = phase_reg + phase_step[PHASE_BITS-1:0];
    assign rom_idx    = phase_next[PHASE_BITS-1 -: SINE_TABLE_BITS];

    assign flags.filt_en = effect_enables[EN_FILTER];
    assign flags.ring_en = effect_enables[EN_RING];
    assign q_data        = {flags, rom_idx, sample_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (q_push)
            phase_reg <= phase_next;
    end

endmodule

### rtl/core/pbrm_queue.sv
// ----------------------------------------------------------------------------
// pbrm_queue: short request queue between front and back
// Two-entry FIFO of packed requests, registered storage.
// ----------------------------------------------------------------------------
module pbrm_queue #(
    parameter int WIDTH = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);
    import pbrm_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]    entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS:0]   count_reg;

    assign full     = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            if ((push && !full) && !(pop && !empty))
                count_reg <= count_reg + (PTR_BITS+1)'(1);
            else if (!(push && !full) && (pop && !empty))
                count_reg <= count_reg - (PTR_BITS+1)'(1);
        end
    end

endmodule

### rtl/core/pbrm_back.sv
// ----------------------------------------------------------------------------
// pbrm_back: filter and ring modulator datapath
// Sequencer around one shared 18x16 multiplier: five MAC steps for the
// biquad, one product for the ring modulator, then the output register.
// ----------------------------------------------------------------------------
module pbrm_back #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  logic [pbrm_pkg::SAMPLE_BITS+SINE_TABLE_BITS+1:0] q_data,
    output logic                      q_pop,
    input  pbrm_pkg::coef_set_t       coefs,
    output logic                      out_valid,
    input  logic                      out_stall,
    output pbrm_pkg::sample_t         sample_out
);
    import pbrm_pkg::*;

    localparam int ROM_DEPTH = 1 << SINE_TABLE_BITS;

    // MAC step numbers
    localparam logic [2:0] TAP_B0 = 3'd0;
    localparam logic [2:0] TAP_B1 = 3'd1;
    localparam logic [2:0] TAP_B2 = 3'd2;
    localparam logic [2:0] TAP_A1 = 3'd3;
    localparam logic [2:0] TAP_A2 = 3'd4;

    localparam logic signed [ACC_BITS-1:0]  FILT_HALF =
        ACC_BITS'(64'sd1 <<< (COEF_FRAC_BITS - 1));
    localparam logic signed [PROD_BITS-1:0] RING_HALF =
        PROD_BITS'(64'sd1 <<< (RING_SHIFT - 1));

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_FILT,
        ST_RING,
        ST_FINISH
    } state_t;

    // Sine ROM, constant contents
    sample_t sine_rom [ROM_DEPTH];
    for (genvar i = 0; i < ROM_DEPTH; i++)
    begin : g_rom
        assign sine_rom[i] = sine_entry(i, SINE_TABLE_BITS);
    end

    // Unpack queue head
    sample_t                    q_sample;
    logic [SINE_TABLE_BITS-1:0] q_idx;
    effect_flags_t              q_flags;
    assign {q_flags, q_idx, q_sample} = q_data;

    state_t                     state_reg, state_next;
    logic [2:0]                 step_reg, step_next;
    sample_t                    x_reg, x_next;
    effect_flags_t              flags_reg, flags_next;
    sample_t                    rom_data_reg;
    logic signed [ACC_BITS-1:0] acc_reg, acc_next;
    sample_t                    s_reg, s_next;
    sample_t                    x1_reg, x1_next;
    sample_t                    x2_reg, x2_next;
    sample_t                    y1_reg, y1_next;
    sample_t                    y2_reg, y2_next;
    logic                       out_valid_reg, out_valid_next;
    sample_t                    sample_out_reg, sample_out_next;

    // Shared multiplier
    coef_t                       mult_a;
    sample_t                     mult_b;
    logic                        mac_sub;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [ACC_BITS-1:0]  acc_rnd;
    logic signed [PROD_BITS-1:0] ring_rnd;

    assign prod     = mult_a * mult_b;
    assign acc_rnd  = acc_reg + FILT_HALF;
    assign ring_rnd = prod + RING_HALF;

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // Operand select and sequencing
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        x_next          = x_reg;
        flags_next      = flags_reg;
        acc_next        = acc_reg;
        s_next          = s_reg;
        x1_next         = x1_reg;
        x2_next         = x2_reg;
        y1_next         = y1_reg;
        y2_next         = y2_reg;
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        q_pop           = 1'b0;
        mult_a          = coefs.b0;
        mult_b          = x_reg;
        mac_sub         = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    x_next     = q_sample;
                    flags_next = q_flags;
                    s_next     = q_sample;
                    acc_next   = '0;
                    step_next  = TAP_B0;
                    if (q_flags.filt_en)
                        state_next = ST_MAC;
                    else if (q_flags.ring_en)
                        state_next = ST_RING;
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_MAC:
            begin
                case (step_reg)
                    TAP_B0:
                    begin
                        mult_a = coefs.b0;
                        mult_b = x_reg;
                    end
                    TAP_B1:
                    begin
                        mult_a = coefs.b1;
                        mult_b = x1_reg;
                    end
                    TAP_B2:
                    begin
                        mult_a = coefs.b2;
                        mult_b = x2_reg;
                    end
                    TAP_A1:
                    begin
                        mult_a  = coefs.a1;
                        mult_b  = y1_reg;
                        mac_sub = 1'b1;
                    end
                    TAP_A2:
                    begin
                        mult_a  = coefs.a2;
                        mult_b  = y2_reg;
                        mac_sub = 1'b1;
                    end
                    default:
                    begin
                        mult_a = coefs.b0;
                        mult_b = x_reg;
                    end
                endcase
                if (mac_sub)
                    acc_next = acc_reg - ACC_BITS'(prod);
                else
                    acc_next = acc_reg + ACC_BITS'(prod);
                if (step_reg == TAP_A2)
                    state_next = ST_FILT;
                else
                    step_next = step_reg + 3'd1;
            end
            ST_FILT:
            begin
                // Round, saturate and shift the history
                s_next  = sat_sample(acc_rnd >>> COEF_FRAC_BITS);
                x2_next = x1_reg;
                x1_next = x_reg;
                y2_next = y1_reg;
                y1_next = sat_sample(acc_rnd >>> COEF_FRAC_BITS);
                if (flags_reg.ring_en)
                    state_next = ST_RING;
                else
                    state_next = ST_FINISH;
            end
            ST_RING:
            begin
                mult_a     = COEF_BITS'(s_reg);
                mult_b     = rom_data_reg;
                s_next     = sat_sample(ACC_BITS'(ring_rnd >>> RING_SHIFT));
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = s_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ROM read, registered, addressed by the request being taken
    always_ff @(posedge clk)
    begin
        if (q_pop)
            rom_data_reg <= sine_rom[q_idx];
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= TAP_B0;
            x_reg          <= '0;
            flags_reg      <= '0;
            acc_reg        <= '0;
            s_reg          <= '0;
            x1_reg         <= '0;
            x2_reg         <= '0;
            y1_reg         <= '0;
            y2_reg         <= '0;
            out_valid_reg  <= 1'b0;
            sample_out_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            x_reg          <= x_next;
            flags_reg      <= flags_next;
            acc_reg        <= acc_next;
            s_reg          <= s_next;
            x1_reg         <= x1_next;
            x2_reg         <= x2_next;
            y1_reg         <= y1_next;
            y2_reg         <= y2_next;
            out_valid_reg  <= out_valid_next;
            sample_out_reg <= sample_out_next;
        end
    end

endmodule

### rtl/core/peaking_biquad_ring_modulator_core.sv
// ----------------------------------------------------------------------------
// peaking_biquad_ring_modulator_core: peaking EQ biquad and ring modulator
// Register file, intake front, request queue and shared-multiplier back end.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_valid / in_stall / sample_in and leave on
//   out_valid / out_stall / sample_out; a request moves on an edge where
//   valid is high and stall is low. Exactly one output per input, in order.
//   Registers are written over the APB port (byte address 4*index): enables,
//   five Q3.14 coefficients, phase step. The user must write them only while
//   no request is in flight; the block itself does not enforce this. The back
//   end takes one sample at a time, running five multiply-accumulate steps for
//   the filter and the ring product on one multiplier; a sample with both
//   stages off skips both.
//   A two-entry queue lets the front keep accepting while the back works;
//   in_stall rises when the queue is full.
//   While out_stall is high the finished sample waits in the output
//   register and the back end holds its next result.
//   Reset clears registers to their defaults, filter history and phase to
//   zero; the sine ROM is constant and needs no initialization.
// ----------------------------------------------------------------------------
module peaking_biquad_ring_modulator_core #(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  pbrm_pkg::sample_t                 sample_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output pbrm_pkg::sample_t                 sample_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pbrm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import pbrm_pkg::*;

    localparam int QW = SAMPLE_BITS + SINE_TABLE_BITS + 2;

    logic [1:0]           enables_reg;
    coef_set_t            coefs_reg;
    logic [STEP_BITS-1:0] phase_step_reg;
    logic [2:0]           reg_index;
    logic                 wr_en;

    logic          q_push, q_full, q_pop, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en     = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enables_reg    <= '0;
            coefs_reg.b0   <= COEF_ONE;
            coefs_reg.b1   <= '0;
            coefs_reg.b2   <= '0;
            coefs_reg.a1   <= '0;
            coefs_reg.a2   <= '0;
            phase_step_reg <= PHASE_STEP_INIT;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_ENABLES:    enables_reg    <= pwdata[1:0];
                REG_B0:         coefs_reg.b0   <= pwdata[COEF_BITS-1:0];
                REG_B1:         coefs_reg.b1   <= pwdata[COEF_BITS-1:0];
                REG_B2:         coefs_reg.b2   <= pwdata[COEF_BITS-1:0];
                REG_A1:         coefs_reg.a1   <= pwdata[COEF_BITS-1:0];
                REG_A2:         coefs_reg.a2   <= pwdata[COEF_BITS-1:0];
                REG_PHASE_STEP: phase_step_reg <= pwdata;
                default:        ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_index)
            REG_ENABLES:    prdata = {30'd0, enables_reg};
            REG_B0:         prdata = 32'(coefs_reg.b0);
            REG_B1:         prdata = 32'(coefs_reg.b1);
            REG_B2:         prdata = 32'(coefs_reg.b2);
            REG_A1:         prdata = 32'(coefs_reg.a1);
            REG_A2:         prdata = 32'(coefs_reg.a2);
            REG_PHASE_STEP: prdata = phase_step_reg;
            default:        prdata = '0;
        endcase
    end

    pbrm_front #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_in      (sample_in),
        .effect_enables (enables_reg),
        .phase_step     (phase_step_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    pbrm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    pbrm_back #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .coefs      (coefs_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out)
    );

endmodule
